FILE: rtl/qsa_pkg.sv
// Types, constants and helpers shared by the quadrature setpoint adjuster.
package qsa_pkg;

	localparam int WeightW = 16;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_WEIGHT_STEP = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MIN_TARGET  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_TARGET  = 2'd2;

	localparam logic [WeightW-1:0] WEIGHT_STEP_RST = 16'd10;
	localparam logic [WeightW-1:0] MIN_TARGET_RST  = 16'd0;
	localparam logic [WeightW-1:0] MAX_TARGET_RST  = 16'hFFFF;

	localparam logic [1:0] PHASE_00 = 2'b00;
	localparam logic [1:0] PHASE_01 = 2'b01;
	localparam logic [1:0] PHASE_11 = 2'b11;
	localparam logic [1:0] PHASE_10 = 2'b10;

	localparam logic signed [3:0] SUB_DETENT = 4'sd4;

	localparam logic signed [1:0] DETENT_NONE = 2'sd0;
	localparam logic signed [1:0] DETENT_FWD  = 2'sd1;
	localparam logic signed [1:0] DETENT_BACK = -2'sd1;

	typedef struct packed {
		logic               mode;
		logic               clk_level;
		logic               dt_level;
		logic               is_idle;
		logic [WeightW-1:0] load_value;
	} qsa_item_t;

	typedef struct packed {
		logic [WeightW-1:0] weight_step;
		logic [WeightW-1:0] min_target;
		logic [WeightW-1:0] max_target;
	} qsa_cfg_t;

	typedef struct packed {
		logic [WeightW-1:0] target_weight;
		logic signed [1:0]  detent_step;
	} qsa_result_t;

	// forward Gray sequence 00 -> 01 -> 11 -> 10 -> 00
	function automatic logic [1:0] next_fwd(input logic [1:0] ph);
		logic [1:0] nx;
		case (ph)
			PHASE_00: nx = PHASE_01;
			PHASE_01: nx = PHASE_11;
			PHASE_11: nx = PHASE_10;
			default:  nx = PHASE_00;
		endcase
		return nx;
	endfunction

endpackage

FILE: rtl/quadrature_setpoint_adjuster.sv
// Top level: stream ports, config registers, input and result registers.
// A request is held in the input register, then in the result register.
// One request per cycle unless stalled: the input stage drains into the
// result register whenever that register is empty or being taken downstream.
// Reset (arst_n low, asynchronous): both stages empty, encoder state and
// setpoint zero, weight_step 10, min_target 0, max_target 65535.
module quadrature_setpoint_adjuster import qsa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [23:0]         s_axis_tdata,  // clk_level, dt_level, is_idle, load_value[15:0], pad
	input  logic                s_axis_tuser,  // mode
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [23:0]         m_axis_tdata,  // target_weight[15:0], detent_step[1:0], pad
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [WeightW-1:0]  cfg_data
);

	qsa_cfg_t    cfg_q;
	qsa_item_t   item_s1;
	logic        valid_s1;
	qsa_result_t res_q;
	qsa_result_t res_d;
	logic        out_valid_q;
	logic        in_fire, advance;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight_step <= WEIGHT_STEP_RST;
			cfg_q.min_target  <= MIN_TARGET_RST;
			cfg_q.max_target  <= MAX_TARGET_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WEIGHT_STEP: cfg_q.weight_step <= cfg_data;
				REG_MIN_TARGET:  cfg_q.min_target  <= cfg_data;
				REG_MAX_TARGET:  cfg_q.max_target  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.mode       <= s_axis_tuser;
			item_s1.clk_level  <= s_axis_tdata[0];
			item_s1.dt_level   <= s_axis_tdata[1];
			item_s1.is_idle    <= s_axis_tdata[2];
			item_s1.load_value <= s_axis_tdata[18:3];
		end
	end

	qsa_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, res_q.detent_step, res_q.target_weight};

endmodule

FILE: rtl/qsa_core.sv
// Encoder state, detent detection, clamped detent update and direct load of the setpoint for one request.
module qsa_core import qsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  qsa_item_t   item,
	input  qsa_cfg_t    cfg,
	output qsa_result_t result
);

	logic [1:0]         last_phase_q, last_phase_d;
	logic signed [3:0]  sub_steps_q, sub_steps_d;
	logic [WeightW-1:0] setpoint_q, setpoint_d;

	logic [1:0]               phase;
	logic                     fwd, bwd;
	logic signed [3:0]        sub_sum;
	logic signed [1:0]        detent;
	logic signed [WeightW+1:0] nt, min_x, max_x, step_x;

	always_comb begin
		phase   = {item.clk_level, item.dt_level};
		fwd     = (next_fwd(last_phase_q) == phase);
		bwd     = (next_fwd(phase) == last_phase_q);
		sub_sum = sub_steps_q + (fwd ? 4'sd1 : (bwd ? -4'sd1 : 4'sd0));
		step_x  = $signed({2'b00, cfg.weight_step});
		min_x   = $signed({2'b00, cfg.min_target});
		max_x   = $signed({2'b00, cfg.max_target});

		last_phase_d = last_phase_q;
		sub_steps_d  = sub_steps_q;
		setpoint_d   = setpoint_q;
		detent       = DETENT_NONE;
		nt           = $signed({2'b00, setpoint_q});

		if (item.mode) begin
			setpoint_d = item.load_value;
		end else begin
			last_phase_d = phase;
			sub_steps_d  = sub_sum;
			if (sub_sum >= SUB_DETENT) begin
				detent      = DETENT_FWD;
				sub_steps_d = 4'sd0;
			end else if (sub_sum <= -SUB_DETENT) begin
				detent      = DETENT_BACK;
				sub_steps_d = 4'sd0;
			end
			if (detent == DETENT_FWD) begin
				nt = $signed({2'b00, setpoint_q}) + step_x;
			end else begin
				nt = $signed({2'b00, setpoint_q}) - step_x;
			end
			if (detent != DETENT_NONE && item.is_idle) begin
				if (nt < min_x) begin
					setpoint_d = cfg.min_target;
				end else if (nt > max_x) begin
					setpoint_d = cfg.max_target;
				end else begin
					setpoint_d = nt[WeightW-1:0];
				end
			end
		end

		result.target_weight = setpoint_d;
		result.detent_step   = detent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= PHASE_00;
			sub_steps_q  <= 4'sd0;
			setpoint_q   <= '0;
		end else if (fire) begin
			last_phase_q <= last_phase_d;
			sub_steps_q  <= sub_steps_d;
			setpoint_q   <= setpoint_d;
		end
	end

endmodule

FILE: rtl/qsa_checker.sv
// Port-level assertions for the quadrature setpoint adjuster, bound to the top level.
module qsa_port_checker import qsa_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or dropped while stalled");

	a_detent_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[17:16] != 2'b10 && m_axis_tdata[23:18] == 6'b0)
		else $error("illegal detent code or nonzero pad");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

	a_no_result_without_request: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tvalid && s_axis_tready) ##1
		(!m_axis_tvalid && !(s_axis_tvalid && s_axis_tready)) |=> !m_axis_tvalid)
		else $error("result appeared with no pending request");

endmodule

bind quadrature_setpoint_adjuster qsa_port_checker u_qsa_checker (.*);

FILE: tb/qsa_checker.sv
// Checker for the quadrature setpoint adjuster: predicts each result and compares it.
module qsa_checker import qsa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [23:0]        s_axis_tdata,  // clk_level, dt_level, is_idle, load_value[15:0], pad
	input  logic               s_axis_tuser,  // mode
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic [23:0]        m_axis_tdata,  // target_weight[15:0], detent_step[1:0], pad
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [WeightW-1:0] cfg_data,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	qsa_cfg_t          limits;
	logic [1:0]        last_phase;
	int                sub_steps;
	logic [WeightW-1:0] setpoint;

	qsa_result_t target_q[$];
	qsa_item_t   req;
	qsa_result_t want;
	qsa_result_t got;
	int          errs = 0;

	// forward Gray step moves {a,b} to {b,~a}
	task automatic advance_setpoint(input qsa_item_t it, output qsa_result_t res);
		logic [1:0]        ph;
		logic signed [1:0] det;
		int                sum;
		ph  = {it.clk_level, it.dt_level};
		det = DETENT_NONE;
		if (it.mode) begin
			setpoint = it.load_value;
		end else begin
			if (ph == {last_phase[0], ~last_phase[1]})
				sub_steps++;
			else if (last_phase == {ph[0], ~ph[1]})
				sub_steps--;
			last_phase = ph;
			if (sub_steps >= int'(SUB_DETENT)) begin
				det       = DETENT_FWD;
				sub_steps = 0;
			end else if (sub_steps <= -int'(SUB_DETENT)) begin
				det       = DETENT_BACK;
				sub_steps = 0;
			end
			sum = int'(setpoint) + int'(det) * int'(limits.weight_step);
			if (det != DETENT_NONE && it.is_idle) begin
				if (sum < int'(limits.min_target))
					setpoint = limits.min_target;
				else if (sum > int'(limits.max_target))
					setpoint = limits.max_target;
				else
					setpoint = sum[WeightW-1:0];
			end
		end
		res.target_weight = setpoint;
		res.detent_step   = det;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits.weight_step = WEIGHT_STEP_RST;
			limits.min_target  = MIN_TARGET_RST;
			limits.max_target  = MAX_TARGET_RST;
			last_phase = PHASE_00;
			sub_steps  = 0;
			setpoint   = '0;
			target_q.delete();
			pending    <= 0;
			fail_count <= errs;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.target_weight = m_axis_tdata[15:0];
				got.detent_step   = m_axis_tdata[17:16];
				if (target_q.size() == 0) begin
					errs++;
					$display("%0t: result with no request pending: target %0d detent %0d",
						$time, got.target_weight, got.detent_step);
				end else begin
					want = target_q.pop_front();
					if (got.target_weight !== want.target_weight) begin
						errs++;
						$display("%0t: target_weight expected %0d got %0d",
							$time, want.target_weight, got.target_weight);
					end
					if (got.detent_step !== want.detent_step) begin
						errs++;
						$display("%0t: detent_step expected %0d got %0d",
							$time, want.detent_step, got.detent_step);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WEIGHT_STEP: limits.weight_step = cfg_data;
					REG_MIN_TARGET:  limits.min_target  = cfg_data;
					REG_MAX_TARGET:  limits.max_target  = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req.mode       = s_axis_tuser;
				req.clk_level  = s_axis_tdata[0];
				req.dt_level   = s_axis_tdata[1];
				req.is_idle    = s_axis_tdata[2];
				req.load_value = s_axis_tdata[18:3];
				advance_setpoint(req, want);
				target_q.push_back(want);
			end
			pending    <= target_q.size();
			fail_count <= errs;
		end
	end

endmodule

FILE: tb/tb_quadrature_setpoint_adjuster.sv
// Testbench top for the quadrature setpoint adjuster: stimulus, stalls, watchdog, verdict.
module tb_quadrature_setpoint_adjuster;
	timeunit 1ns;
	timeprecision 1ps;
	import qsa_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
	localparam int StallMax   = 13;
	localparam int WatchLimit = 1000;
	localparam int PhaseItems = 190;
	localparam int NumPhases  = 7;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [23:0]        s_axis_tdata = '0;  // clk_level, dt_level, is_idle, load_value[15:0], pad
	logic               s_axis_tuser = 1'b0;  // mode
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [23:0]        m_axis_tdata;  // target_weight[15:0], detent_step[1:0], pad
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [WeightW-1:0] cfg_data = '0;
	int                 fail_count;
	int                 pending;

	logic [1:0] cur_phase = PHASE_00;
	bit         tx_calm = 1'b0;

	quadrature_setpoint_adjuster u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	qsa_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side back-pressure, with calm stretches
	initial begin
		int stall;
		int taken;
		stall = 0;
		taken = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				taken++;
				stall = (taken % 120 < 35) ? 0 : $urandom_range(0, StallMax);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int stuck;
		stuck = 0;
		while (stuck < WatchLimit) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("tb_quadrature_setpoint_adjuster NOT OK");
		$finish;
	end

	task automatic push_sample(input qsa_item_t it);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, StallMax);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, it.load_value, it.is_idle, it.dt_level, it.clk_level};
		s_axis_tuser  <= it.mode;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic move_pins(input logic [1:0] ph, input logic idle);
		qsa_item_t it;
		it.mode       = 1'b0;
		it.clk_level  = ph[1];
		it.dt_level   = ph[0];
		it.is_idle    = idle;
		it.load_value = WeightW'($urandom());
		cur_phase     = ph;
		push_sample(it);
	endtask

	task automatic gray_step(input bit fwd, input logic idle);
		move_pins(fwd ? {cur_phase[0], ~cur_phase[1]} : {~cur_phase[0], cur_phase[1]}, idle);
	endtask

	task automatic full_detent(input bit fwd, input logic idle);
		repeat (4) gray_step(fwd, idle);
	endtask

	task automatic load_target(input logic [WeightW-1:0] val);
		qsa_item_t it;
		it.mode       = 1'b1;
		it.clk_level  = 1'($urandom_range(0, 1));
		it.dt_level   = 1'($urandom_range(0, 1));
		it.is_idle    = 1'($urandom_range(0, 1));
		it.load_value = val;
		push_sample(it);
	endtask

	// drain all results, then let the pipeline empty before touching registers
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WeightW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_limits(input logic [WeightW-1:0] step, input logic [WeightW-1:0] lo,
			input logic [WeightW-1:0] hi);
		settle();
		write_reg(REG_WEIGHT_STEP, step);
		write_reg(REG_MIN_TARGET, lo);
		write_reg(REG_MAX_TARGET, hi);
		write_reg(REG_UNUSED, WeightW'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [WeightW-1:0] step;
		logic [WeightW-1:0] lo;
		logic [WeightW-1:0] hi;
		logic [WeightW-1:0] lv;
		bit                 fwd;
		int                 pick;
		logic               idle;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: up one detent, same phase, down to zero, below zero clamps
		full_detent(1'b1, 1'b1);
		move_pins(cur_phase, 1'b1);
		full_detent(1'b0, 1'b1);
		full_detent(1'b0, 1'b1);
		// double jumps count nothing
		move_pins(~cur_phase, 1'b1);
		move_pins(~cur_phase, 1'b1);
		// detent while busy leaves the setpoint alone
		full_detent(1'b1, 1'b0);
		load_target(16'hFFFF);
		full_detent(1'b1, 1'b1);
		load_target(16'h0000);

		// a detent with zero step still clamps an out-of-range loaded setpoint
		program_limits(16'd0, 16'd100, 16'd200);
		load_target(16'd5000);
		full_detent(1'b1, 1'b1);

		fwd = 1'b1;
		for (int ph = 0; ph < NumPhases; ph++) begin
			case (ph)
				0: begin step = WEIGHT_STEP_RST; lo = 16'd0; hi = 16'hFFFF; end
				1: begin step = 16'd1; lo = 16'd0; hi = 16'hFFFF; end
				2: begin step = 16'hFFFF; lo = 16'd0; hi = 16'hFFFF; end
				3: begin step = 16'd1000; lo = 16'd20000; hi = 16'd45000; end
				4: begin step = 16'd500; lo = 16'd1000; hi = 16'd1000; end
				5: begin
					step = WeightW'($urandom_range(1, 65535));
					lo   = 16'd40000;
					hi   = 16'd20000;
				end
				default: begin
					step = WeightW'($urandom_range(1, 65535));
					lo   = WeightW'($urandom());
					hi   = WeightW'($urandom());
					if (lo > hi) begin
						lv = lo;
						lo = hi;
						hi = lv;
					end
				end
			endcase
			program_limits(step, lo, hi);
			for (int n = 0; n < PhaseItems; n++) begin
				if (n % 50 == 0)
					tx_calm = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 5) == 0)
					fwd = ~fwd;
				pick = $urandom_range(0, 99);
				idle = ($urandom_range(0, 7) != 0);
				if (pick < 4) begin
					lv = WeightW'($urandom());
					if ($urandom_range(0, 4) == 0)
						lv = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					load_target(lv);
				end else if (pick < 8) begin
					move_pins(~cur_phase, idle);
				end else if (pick < 12) begin
					move_pins(cur_phase, idle);
				end else begin
					gray_step(fwd, idle);
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_quadrature_setpoint_adjuster OK");
		else
			$display("tb_quadrature_setpoint_adjuster NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/qsa_pkg.sv
rtl/qsa_core.sv
rtl/quadrature_setpoint_adjuster.sv
rtl/qsa_checker.sv
tb/qsa_checker.sv
tb/tb_quadrature_setpoint_adjuster.sv
